@@ sv/rwq_pkg.sv @@
// Shared types and constants for the rolling window quantile core.
// Depends on nothing; every other file imports it.
package rwq_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int WLEN_W         = 7;
    localparam int Q_W            = 16;
    localparam int MINC_W         = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int VAL_W          = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTILE_Q    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT     = 2'd2;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd64;
    localparam logic [Q_W-1:0]    Q_RESET    = 16'd32768;
    localparam logic [MINC_W-1:0] MINC_RESET = 7'd1;

    typedef struct packed {
        logic signed [VAL_W-1:0] sample;
        logic                    sample_finite;
        logic                    series_start;
    } in_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] quantile_value;
        logic                    result_valid;
    } out_word_t;

    typedef struct packed {
        logic take;
        logic prep;
        logic scan;
        logic rank;
        logic sel;
        logic mul;
        logic fin;
    } rwq_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic sel_done;
        logic out_full;
    } rwq_stat_t;

endpackage

@@ sv/rwq_ctrl.sv @@
// Sequencer for the rolling window quantile core.
// Depends on rwq_pkg for the command and status structs.
module rwq_ctrl
    import rwq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  rwq_stat_t stat,
    output rwq_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RANK = 3'd3;
    localparam logic [2:0] S_SEL  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_RANK;
                end
            end
            S_RANK:
            begin
                cmd.rank   = 1'b1;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                cmd.sel = 1'b1;
                if (stat.sel_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold the result until the output register frees up
                if (!stat.out_full)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

@@ sv/rwq_dp.sv @@
// Datapath of the rolling window quantile core: sample ring, sorted cell row,
// rank and interpolation arithmetic, output register. Depends on rwq_pkg.
module rwq_dp
    import rwq_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rwq_cmd_t              cmd,
    output rwq_stat_t             stat,
    input  in_word_t              in_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_word
);

    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
    localparam int PRD_W = Q_W + CNT_W;

    // configuration
    logic [WLEN_W-1:0] wlen_reg;
    logic [Q_W-1:0]    q_reg;
    logic [MINC_W-1:0] minc_reg;

    // ring store
    logic signed [VAL_W-1:0] mem_val [WINDOW_MAX];
    logic                    mem_fin [WINDOW_MAX];
    logic signed [VAL_W-1:0] rd_val_reg;
    logic                    rd_fin_reg;
    logic                    rd_vld_reg;

    logic [PTR_W-1:0] ptr_reg;
    logic [CNT_W-1:0] items_reg;
    logic [PTR_W-1:0] ptr_eff;
    logic [CNT_W-1:0] items_eff;

    logic [PTR_W-1:0] idx_reg;
    logic [PTR_W-1:0] idx_dec;
    logic [CNT_W-1:0] m_reg;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] nonfin_reg;
    logic             rd_en;

    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] items_cmp;

    // sorted cell row
    logic signed [VAL_W-1:0] row_reg  [WINDOW_MAX];
    logic signed [VAL_W-1:0] row_next [WINDOW_MAX];
    logic                    gt       [WINDOW_MAX];

    // arithmetic
    logic [PRD_W-1:0]        prod_reg;
    logic [CNT_W-1:0]        cntm1;
    logic [CNT_W-1:0]        k_sel;
    logic [Q_W-1:0]          frac;
    logic [CNT_W-1:0]        sel_cnt_reg;
    logic signed [VAL_W:0]   diff;
    logic signed [VAL_W+Q_W+1:0] mprod_reg;
    logic signed [VAL_W-1:0] interp;
    logic                    res_ok;

    logic      out_valid_reg;
    out_word_t out_word_reg;

    assign ptr_eff   = in_word.series_start ? '0 : ptr_reg;
    assign items_eff = in_word.series_start ? '0 : items_reg;
    assign idx_dec   = (idx_reg == '0) ? PTR_W'(WINDOW_MAX - 1) : idx_reg - 1'b1;
    assign rd_en     = cmd.scan && (scan_cnt_reg != m_reg);

    assign w_eff     = (CMP_W'(wlen_reg) > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX)
                                                               : CMP_W'(wlen_reg);
    assign items_cmp = CMP_W'(items_reg);

    assign cntm1 = (fill_reg == '0) ? '0 : fill_reg - 1'b1;
    assign k_sel = prod_reg[Q_W +: CNT_W];
    assign frac  = prod_reg[Q_W-1:0];
    assign diff  = {row_reg[1][VAL_W-1], row_reg[1]} - {row_reg[0][VAL_W-1], row_reg[0]};
    assign interp = row_reg[0] + mprod_reg[Q_W +: VAL_W];

    assign res_ok = (wlen_reg != '0) && (q_reg != '0) && (nonfin_reg == '0) &&
                    (CMP_W'(m_reg) >= CMP_W'(minc_reg)) && (fill_reg != '0);

    assign stat.scan_done = (scan_cnt_reg == m_reg) && !rd_vld_reg;
    assign stat.sel_done  = (sel_cnt_reg == k_sel);
    assign stat.out_full  = out_valid_reg && out_stall;

    // insert position: cells at or past the fill count count as greater
    always_comb
    begin
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            gt[i] = (CNT_W'(i) >= fill_reg) || (row_reg[i] > rd_val_reg);
        end
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            row_next[i] = row_reg[i];
        end
        if (cmd.sel && !stat.sel_done)
        begin
            for (int i = 0; i < WINDOW_MAX - 1; i++)
            begin
                row_next[i] = row_reg[i + 1];
            end
        end
        else if (cmd.scan && rd_vld_reg && rd_fin_reg)
        begin
            if (gt[0])
            begin
                row_next[0] = rd_val_reg;
            end
            for (int i = 1; i < WINDOW_MAX; i++)
            begin
                if (gt[i])
                begin
                    row_next[i] = gt[i - 1] ? row_reg[i - 1] : rd_val_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mem_val[ptr_eff] <= in_word.sample;
            mem_fin[ptr_eff] <= in_word.sample_finite;
        end
        if (rd_en)
        begin
            rd_val_reg <= mem_val[idx_dec];
            rd_fin_reg <= mem_fin[idx_dec];
        end
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            row_reg[i] <= row_next[i];
        end
        if (cmd.rank)
        begin
            prod_reg <= PRD_W'(q_reg) * PRD_W'(cntm1);
        end
        if (cmd.mul)
        begin
            mprod_reg <= $signed({1'b0, frac}) * diff;
        end
        if (cmd.fin)
        begin
            out_word_reg.result_valid   <= res_ok;
            out_word_reg.quantile_value <= !res_ok ? '0 :
                                           (frac == '0) ? row_reg[0] : interp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= WLEN_RESET;
            q_reg         <= Q_RESET;
            minc_reg      <= MINC_RESET;
            ptr_reg       <= '0;
            items_reg     <= '0;
            idx_reg       <= '0;
            m_reg         <= '0;
            scan_cnt_reg  <= '0;
            fill_reg      <= '0;
            nonfin_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            sel_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_LENGTH: wlen_reg <= cfg_data[WLEN_W-1:0];
                    CFG_QUANTILE_Q:    q_reg    <= cfg_data[Q_W-1:0];
                    CFG_MIN_COUNT:     minc_reg <= cfg_data[MINC_W-1:0];
                    default:           ;
                endcase
            end
            if (cmd.take)
            begin
                ptr_reg   <= (ptr_eff == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr_eff + 1'b1;
                items_reg <= (items_eff == CNT_W'(WINDOW_MAX)) ? items_eff
                                                               : items_eff + 1'b1;
            end
            if (cmd.prep)
            begin
                m_reg        <= (items_cmp < w_eff) ? items_reg : CNT_W'(w_eff);
                idx_reg      <= ptr_reg;
                scan_cnt_reg <= '0;
                fill_reg     <= '0;
                nonfin_reg   <= '0;
                rd_vld_reg   <= 1'b0;
            end
            if (cmd.scan)
            begin
                rd_vld_reg <= rd_en;
                if (rd_en)
                begin
                    idx_reg      <= idx_dec;
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (rd_fin_reg)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    else
                    begin
                        nonfin_reg <= nonfin_reg + 1'b1;
                    end
                end
            end
            if (cmd.rank)
            begin
                sel_cnt_reg <= '0;
            end
            if (cmd.sel && !stat.sel_done)
            begin
                sel_cnt_reg <= sel_cnt_reg + 1'b1;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.fin)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

@@ sv/rolling_window_quantile_core.sv @@
// Top level of the rolling window quantile core.
// Depends on rwq_pkg, rwq_ctrl and rwq_dp.
//
// Exact quantile over the last window_length Q16.16 samples, interpolated
// linearly between neighboring order statistics, one result word per input
// word. The core works on one word at a time: after a word is taken it
// stalls the input through the prepare, scan, rank, select, multiply and
// finish steps; the scan does one ring read and one insert into the sorted
// cell row per window sample, and the select one shift of the sorted row
// per step of the integer rank q*(count-1). A finished result waits in the
// output register, so the next word is taken while the previous result is
// still stalled downstream; the last step holds, and stretches the input
// stall, only while that register is still full. A zero window_length or
// q, a window with a non-finite sample, fewer than min_count samples, or
// no finite samples gives result_valid 0 and value 0. series_start clears
// the window before its own sample. Write configuration only while idle.
module rolling_window_quantile_core
    import rwq_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    rwq_cmd_t  cmd;
    rwq_stat_t stat;

    // sequence the steps: take, prepare, scan ring, rank, select, multiply, finish
    rwq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold the ring, rebuild the sorted row, compute the quantile
    rwq_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_word   (in_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

@@ sv/rwq_checker.sv @@
// Port-level checks for the rolling window quantile core, bound to the top.
// Depends on rwq_pkg.
module rwq_checker
    import rwq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_word_t  in_word,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_word
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.result_valid |-> out_word.quantile_value == '0)
        else $error("invalid result carries nonzero value");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again without processing");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result appeared one cycle after a take");

endmodule

bind rolling_window_quantile_core rwq_checker u_rwq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

@@ bench/tb_rolling_window_quantile_core.sv @@
// Testbench for rolling_window_quantile_core: drives random and directed words,
// predicts each window quantile and compares result words in order.
// Depends on rwq_pkg and the core RTL.
module tb_rolling_window_quantile_core;
    import rwq_pkg::*;

    localparam int WMAX = WINDOW_MAX_DEF;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_word;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_word;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rolling_window_quantile_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state: ring of past samples plus the register copies.
    logic signed [31:0] hist_val [WMAX];
    logic               hist_fin [WMAX];
    int unsigned        seen_cnt;
    int unsigned        wr_ptr;
    int unsigned        win_len;
    int unsigned        q_frac;
    int unsigned        min_fill;

    out_word_t   quantile_q_exp [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned valid_seen;
    bit          sender_idle_on;
    bit          receiver_idle_on;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit: far above the slowest legal run (under a thousand words,
    // each with its processing steps and random stalls).
    initial
    begin
        #(12 * 600000);
        $display("Timeout with %0d results still pending", quantile_q_exp.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Compute the expected result word for one sample and advance the ring.
    function automatic out_word_t predict_quantile(in_word_t w);
        logic signed [31:0] sorted [WMAX];
        logic signed [31:0] v;
        logic signed [31:0] res;
        logic signed [63:0] diff;
        logic signed [63:0] prod_s;
        logic [63:0]        prod;
        int unsigned wl, fill, nfin, nbad, idx, k, frac, p;
        out_word_t o;
        if (w.series_start)
        begin
            seen_cnt = 0;
            wr_ptr   = 0;
        end
        hist_val[wr_ptr] = w.sample;
        hist_fin[wr_ptr] = w.sample_finite;
        wr_ptr = (wr_ptr + 1 >= WMAX) ? 0 : wr_ptr + 1;
        if (seen_cnt < WMAX)
            seen_cnt++;
        wl   = (win_len > WMAX) ? WMAX : win_len;
        fill = (seen_cnt < wl) ? seen_cnt : wl;
        nfin = 0;
        nbad = 0;
        idx  = wr_ptr;
        for (int j = 0; j < fill; j++)
        begin
            idx = (idx == 0) ? WMAX - 1 : idx - 1;
            if (hist_fin[idx])
            begin
                // insertion sort, ascending
                v = hist_val[idx];
                p = nfin;
                while (p > 0 && sorted[p-1] > v)
                begin
                    sorted[p] = sorted[p-1];
                    p--;
                end
                sorted[p] = v;
                nfin++;
            end
            else
                nbad++;
        end
        o = '0;
        if (wl > 0 && q_frac > 0 && nbad == 0 && fill >= min_fill && nfin > 0)
        begin
            prod = 64'(q_frac) * 64'(nfin - 1);
            k    = 32'(prod >> 16);
            frac = 32'(prod[15:0]);
            if (k >= nfin)
                k = nfin - 1;
            res = sorted[k];
            if (frac > 0 && k + 1 < nfin)
            begin
                diff   = 64'(sorted[k+1]) - 64'(res);
                prod_s = 64'(frac) * diff;
                res    = res + 32'(prod_s >>> 16);
            end
            o.quantile_value = res;
            o.result_valid   = 1'b1;
        end
        return o;
    endfunction

    // Hold a word until accepted, with random leading idle bursts.
    task automatic send_sample(logic signed [31:0] s, bit fin, bit start);
        in_word_t w;
        w.sample        = s;
        w.sample_finite = fin;
        w.series_start  = start;
        if (sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        quantile_q_exp.push_back(predict_quantile(w));
        // drop valid; the core stalls the input after a take
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (quantile_q_exp.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WINDOW_LENGTH: win_len  = val & 32'h7F;
            CFG_QUANTILE_Q:    q_frac   = val & 32'hFFFF;
            default:           min_fill = val & 32'h7F;
        endcase
    endtask

    // Compare every accepted result word against the oldest prediction.
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (out_word.result_valid)
                valid_seen++;
            if (quantile_q_exp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %h", out_word);
            end
            else
            begin
                e = quantile_q_exp.pop_front();
                if (e.quantile_value !== out_word.quantile_value ||
                    e.result_valid !== out_word.result_valid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected value %h valid %b, got %h valid %b",
                                 e.quantile_value, e.result_valid,
                                 out_word.quantile_value, out_word.result_valid);
                end
            end
        end
    end

    // Receiver stall: random bursts while enabled.
    always @(posedge clk)
    begin
        int unsigned burst;
        if (!rst_n || !receiver_idle_on)
            out_stall <= 1'b0;
        else if (burst > 0)
            burst--;
        else if ($urandom_range(0, 4) == 0)
        begin
            out_stall <= 1'b1;
            burst = $urandom_range(1, 6);
        end
        else
            out_stall <= 1'b0;
    end

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 2000)) - 1000;
            2:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 9)
                                                 : 32'h80000000 + $urandom_range(0, 9);
        endcase
    endfunction

    // Extremes of the sample, sign extremes in one window, NaN sliding out.
    task automatic test_directed_extremes();
        send_sample(32'sh7FFFFFFF, 1, 1);
        send_sample(32'sh80000000, 1, 0);
        send_sample(32'sh00000000, 1, 0);
        send_sample(32'shFFFFFFFF, 1, 0);
        send_sample(32'sh00010000, 0, 0);
        send_sample(32'sh12345678, 1, 0);
        write_reg(CFG_WINDOW_LENGTH, 2);
        send_sample(32'sh00020000, 1, 0);
        send_sample(32'sh00030000, 1, 0);
        send_sample(32'sh00000000, 0, 0);
        send_sample(32'sh00040000, 1, 0);
        send_sample(32'sh00050000, 1, 0);
        send_sample(32'sh7FFFFFFF, 1, 1);
    endtask

    // Zero and oversized windows, zero and extreme quantiles, minimum fill.
    task automatic test_register_corners();
        write_reg(CFG_WINDOW_LENGTH, 0);
        send_sample(32'sh00010000, 1, 0);
        write_reg(CFG_WINDOW_LENGTH, 127);
        write_reg(CFG_QUANTILE_Q, 0);
        send_sample(32'sh00010000, 1, 0);
        write_reg(CFG_QUANTILE_Q, 65535);
        send_sample(32'sh80000000, 1, 0);
        write_reg(CFG_QUANTILE_Q, 1);
        send_sample(32'sh7FFFFFFF, 1, 0);
        write_reg(CFG_MIN_COUNT, 0);
        send_sample(32'sh00000000, 0, 1);
        write_reg(CFG_MIN_COUNT, 127);
        send_sample(32'sh00000001, 1, 0);
        write_reg(CFG_MIN_COUNT, 3);
        send_sample(32'sh00000002, 1, 1);
        send_sample(32'sh00000003, 1, 0);
        send_sample(32'sh00000004, 1, 0);
    endtask

    // Random phases over several settings; mostly finite samples, few restarts.
    task automatic test_random_phases();
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 8)
            begin
                sender_idle_on   = 0;
                receiver_idle_on = 0;
            end
            write_reg(CFG_WINDOW_LENGTH, (ph % 3 == 0) ? 64 : $urandom_range(1, 20));
            write_reg(CFG_QUANTILE_Q, (ph == 1) ? 65535 : $urandom_range(1, 65535));
            write_reg(CFG_MIN_COUNT, $urandom_range(0, 4));
            for (int i = 0; i < 50; i++)
                send_sample(rand_sample(), $urandom_range(0, 19) != 0,
                            $urandom_range(0, 39) == 0);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_WINDOW_LENGTH;
        cfg_data  = '0;
        mismatches   = 0;
        results_seen = 0;
        valid_seen   = 0;
        seen_cnt = 0;
        wr_ptr   = 0;
        win_len  = WLEN_RESET;
        q_frac   = Q_RESET;
        min_fill = MINC_RESET;
        sender_idle_on   = 1;
        receiver_idle_on = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_register_corners();
        test_random_phases();
        drain_results();

        $display("Checked %0d result words (%0d valid) over varied window, quantile",
                 results_seen, valid_seen);
        $display("and minimum-fill settings, with non-finite samples and restarts.");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ sim.f @@
sv/rwq_pkg.sv
sv/rwq_ctrl.sv
sv/rwq_dp.sv
sv/rolling_window_quantile_core.sv
sv/rwq_checker.sv
bench/tb_rolling_window_quantile_core.sv
